[src/imu_axis_orientation_calibrator_unit_macros.svh]
// assertion macros for the imu axis orientation calibrator
// used by the checker bound to the top level, no other dependencies
`ifndef IMU_AXIS_ORIENTATION_CALIBRATOR_UNIT_MACROS_SVH
`define IMU_AXIS_ORIENTATION_CALIBRATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define IAOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("iaoc assertion failed");

// next-cycle implication, disabled during reset
`define IAOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("iaoc assertion failed");

`endif

[src/iaoc_pkg.sv]
// shared widths, types and constants of the imu axis orientation calibrator
// no dependencies
package iaoc_pkg;

  localparam int unsigned AccW           = 16;
  localparam int unsigned SumW           = 24;
  localparam int unsigned CntW           = 8;
  localparam int unsigned ThrW           = 15;
  localparam int unsigned AxisW          = 2;
  localparam int unsigned NumAxes        = 3;
  localparam int unsigned SamplesDefault = 100;
  localparam int unsigned ThrReset       = 819;

  localparam int unsigned BodyX = 0;
  localparam int unsigned BodyY = 1;
  localparam int unsigned BodyZ = 2;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [SumW-1:0] sum_t;

  typedef enum logic [1:0] {
    PhStatic = 2'd0,
    PhPitch  = 2'd1,
    PhRoll   = 2'd2,
    PhDone   = 2'd3
  } iaoc_phase_e;

  typedef struct packed {
    iaoc_phase_e                     phase;
    logic [CntW-1:0]                 count;
    logic [NumAxes-1:0][AxisW-1:0]   axis_map;
    logic [NumAxes-1:0]              acc_neg;
    logic [NumAxes-1:0]              gyro_neg;
  } iaoc_state_t;

  typedef struct packed {
    iaoc_phase_e        phase;
    logic [AxisW-1:0]   z_src;
    logic [AxisW-1:0]   y_src;
    logic [AxisW-1:0]   x_src;
    logic [NumAxes-1:0] acc_neg_mask;
    logic [NumAxes-1:0] gyro_neg_mask;
  } iaoc_res_t;

  localparam iaoc_state_t StateReset = '{
    phase:    PhStatic,
    count:    '0,
    axis_map: {AxisW'(2), AxisW'(1), AxisW'(0)},
    acc_neg:  '0,
    gyro_neg: '0
  };

endpackage

[src/iaoc_bias_div.sv]
// per-axis division of the accel sums by the sample count
// reciprocal multiply with a registered quotient, uses iaoc_pkg
module iaoc_bias_div #(
  parameter int unsigned Samples = iaoc_pkg::SamplesDefault
) (
  input  logic          clk_i,
  input  iaoc_pkg::sum_t sum_i  [iaoc_pkg::NumAxes],
  output iaoc_pkg::acc_t bias_o [iaoc_pkg::NumAxes]
);
  import iaoc_pkg::*;

  localparam int unsigned AbsW  = SumW - 1;
  localparam int unsigned Shift = AbsW + $clog2(Samples);
  localparam int unsigned RecW  = AbsW + 2;
  localparam int unsigned ProdW = AbsW + RecW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << Shift) + 64'(Samples) - 64'd1) / 64'(Samples));

  logic [AbsW-1:0]  abs_v  [NumAxes];
  logic [ProdW-1:0] prod   [NumAxes];
  logic [AccW-1:0]  qmag   [NumAxes];
  acc_t             bias_d [NumAxes];

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      abs_v[i]  = sum_i[i][SumW-1] ? AbsW'(-sum_i[i]) : AbsW'(sum_i[i]);
      prod[i]   = {{RecW{1'b0}}, abs_v[i]} * {{AbsW{1'b0}}, Recip};
      qmag[i]   = AccW'(prod[i] >> Shift);
      bias_d[i] = sum_i[i][SumW-1] ? acc_t'(-qmag[i]) : acc_t'(qmag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    bias_o <= bias_d;
  end

endmodule

[src/iaoc_update.sv]
// next-state logic for one sample: averaging, z pick, pitch and roll search
// purely combinational, uses iaoc_pkg
module iaoc_update #(
  parameter int unsigned Samples = iaoc_pkg::SamplesDefault
) (
  input  iaoc_pkg::iaoc_state_t       state_i,
  input  logic                        halt_i,
  input  iaoc_pkg::acc_t              acc_i      [iaoc_pkg::NumAxes],
  input  iaoc_pkg::sum_t              acc_sum_i  [iaoc_pkg::NumAxes],
  input  iaoc_pkg::acc_t              acc_bias_i [iaoc_pkg::NumAxes],
  input  iaoc_pkg::acc_t              quot_i     [iaoc_pkg::NumAxes],
  input  logic [iaoc_pkg::ThrW-1:0]   thr_i,
  output iaoc_pkg::iaoc_state_t       state_o,
  output iaoc_pkg::sum_t              acc_sum_o  [iaoc_pkg::NumAxes],
  output iaoc_pkg::acc_t              acc_bias_o [iaoc_pkg::NumAxes]
);
  import iaoc_pkg::*;

  logic signed [AccW:0] corr     [NumAxes];
  logic [AccW:0]        corr_mag [NumAxes];
  logic [AccW:0]        bias_mag [NumAxes];
  logic [AccW:0]        thr_ext;
  logic [AxisW-1:0]     best;
  logic [AxisW-1:0]     rest;
  logic                 found;

  assign thr_ext = (AccW+1)'(thr_i);

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      corr[i]     = {acc_i[i][AccW-1], acc_i[i]} - {acc_bias_i[i][AccW-1], acc_bias_i[i]};
      corr_mag[i] = corr[i][AccW] ? -corr[i] : corr[i];
      bias_mag[i] = quot_i[i][AccW-1] ? -{quot_i[i][AccW-1], quot_i[i]}
                                      : {quot_i[i][AccW-1], quot_i[i]};
    end
    best = AxisW'(0);
    if (bias_mag[1] > bias_mag[0]) begin
      best = AxisW'(1);
    end
    if (bias_mag[2] > bias_mag[best]) begin
      best = AxisW'(2);
    end
  end

  always_comb begin
    state_o    = state_i;
    acc_sum_o  = acc_sum_i;
    acc_bias_o = acc_bias_i;
    found      = 1'b0;
    rest       = '0;
    if (halt_i) begin
      state_o.phase = PhStatic;
      state_o.count = '0;
    end else begin
      if (state_o.phase == PhStatic) begin
        if (state_i.count < CntW'(Samples)) begin
          for (int i = 0; i < NumAxes; i++) begin
            if (state_i.count == '0) begin
              acc_sum_o[i]  = SumW'(acc_i[i]);
              acc_bias_o[i] = '0;
            end else begin
              acc_sum_o[i] = acc_sum_i[i] + SumW'(acc_i[i]);
            end
          end
          state_o.count = state_i.count + CntW'(1);
        end else begin
          acc_bias_o                = quot_i;
          state_o.axis_map[BodyZ]   = best;
          state_o.acc_neg[BodyZ]    = quot_i[best][AccW-1];
          state_o.gyro_neg[BodyY]   = !quot_i[best][AccW-1];
          state_o.phase             = PhPitch;
        end
      end
      // first qualifying axis wins
      if (state_o.phase == PhPitch) begin
        for (int i = 0; i < NumAxes; i++) begin
          if (!found && AxisW'(i) != state_o.axis_map[BodyZ] && corr_mag[i] > thr_ext) begin
            found                   = 1'b1;
            state_o.axis_map[BodyY] = AxisW'(i);
            state_o.acc_neg[BodyY]  = corr[i][AccW];
            state_o.gyro_neg[BodyX] = corr[i][AccW];
            state_o.phase           = PhRoll;
          end
        end
      end
      if (state_o.phase == PhRoll) begin
        rest = AxisW'(NumAxes) - state_o.axis_map[BodyY] - state_o.axis_map[BodyZ];
        if (rest >= AxisW'(NumAxes)) begin
          rest = '0;
        end
        if (corr_mag[rest] > thr_ext) begin
          state_o.axis_map[BodyX] = rest;
          state_o.acc_neg[BodyX]  = corr[rest][AccW];
          state_o.gyro_neg[BodyY] = corr[rest][AccW];
          state_o.phase           = PhDone;
        end
      end
    end
  end

endmodule

[src/imu_axis_orientation_calibrator_unit.sv]
// top level of the imu axis orientation calibrator
// depends on iaoc_pkg, iaoc_bias_div and iaoc_update
//
// One sample beat is taken per clock cycle, sustained, while the output is taken
// and no stall holds; every sample yields one result beat (input register, then
// result register). The only internal stall: the sample that closes averaging
// waits when it arrives directly behind the last summed sample, while the registered
// per-axis reciprocal multiply in the bias divider catches up with the sums.
// The threshold write port is always ready; write it only while idle.
module imu_axis_orientation_calibrator_unit #(
  parameter int unsigned Samples = iaoc_pkg::SamplesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [iaoc_pkg::ThrW-1:0]      cfg_gravity_threshold_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  iaoc_pkg::acc_t                 acc_x_i,
  input  iaoc_pkg::acc_t                 acc_y_i,
  input  iaoc_pkg::acc_t                 acc_z_i,
  input  iaoc_pkg::acc_t                 gyro_x_i,
  input  iaoc_pkg::acc_t                 gyro_y_i,
  input  iaoc_pkg::acc_t                 gyro_z_i,
  input  logic                           halt_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     phase_o,
  output logic [iaoc_pkg::AxisW-1:0]     z_source_o,
  output logic [iaoc_pkg::AxisW-1:0]     y_source_o,
  output logic [iaoc_pkg::AxisW-1:0]     x_source_o,
  output logic [iaoc_pkg::NumAxes-1:0]   acc_neg_mask_o,
  output logic [iaoc_pkg::NumAxes-1:0]   gyro_neg_mask_o
);
  import iaoc_pkg::*;

  logic              in_vld_q;
  acc_t              in_acc_q  [NumAxes];
  logic              in_halt_q;
  logic [ThrW-1:0]   thr_q;
  iaoc_state_t       state_q;
  iaoc_state_t       state_d;
  sum_t              acc_sum_q [NumAxes];
  sum_t              acc_sum_d [NumAxes];
  acc_t              acc_bias_q [NumAxes];
  acc_t              acc_bias_d [NumAxes];
  acc_t              quot       [NumAxes];
  logic              sum_chg_q;
  logic              out_vld_q;
  iaoc_res_t         res_q;
  iaoc_res_t         res_d;
  logic              stall;
  logic              adv;

  assign cfg_ready_o = 1'b1;

  // closing sample needs quotients of the settled sums
  assign stall = !in_halt_q && state_q.phase == PhStatic &&
                 !(state_q.count < CntW'(Samples)) && sum_chg_q;
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i) && !stall;
  assign in_ready_o = !in_vld_q || adv;

  iaoc_bias_div #(
    .Samples(Samples)
  ) u_bias_div (
    .clk_i  (clk_i),
    .sum_i  (acc_sum_q),
    .bias_o (quot)
  );

  iaoc_update #(
    .Samples(Samples)
  ) u_update (
    .state_i    (state_q),
    .halt_i     (in_halt_q),
    .acc_i      (in_acc_q),
    .acc_sum_i  (acc_sum_q),
    .acc_bias_i (acc_bias_q),
    .quot_i     (quot),
    .thr_i      (thr_q),
    .state_o    (state_d),
    .acc_sum_o  (acc_sum_d),
    .acc_bias_o (acc_bias_d)
  );

  always_comb begin
    res_d.phase         = state_d.phase;
    res_d.z_src         = state_d.axis_map[BodyZ];
    res_d.y_src         = state_d.axis_map[BodyY];
    res_d.x_src         = state_d.axis_map[BodyX];
    res_d.acc_neg_mask  = state_d.acc_neg;
    res_d.gyro_neg_mask = state_d.gyro_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(ThrReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_gravity_threshold_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_acc_q[0] <= acc_x_i;
      in_acc_q[1] <= acc_y_i;
      in_acc_q[2] <= acc_z_i;
      in_halt_q   <= halt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StateReset;
      acc_sum_q  <= '{default: '0};
      acc_bias_q <= '{default: '0};
      sum_chg_q  <= 1'b0;
    end else begin
      sum_chg_q <= adv;
      if (adv) begin
        state_q    <= state_d;
        acc_sum_q  <= acc_sum_d;
        acc_bias_q <= acc_bias_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign phase_o         = res_q.phase;
  assign z_source_o      = res_q.z_src;
  assign y_source_o      = res_q.y_src;
  assign x_source_o      = res_q.x_src;
  assign acc_neg_mask_o  = res_q.acc_neg_mask;
  assign gyro_neg_mask_o = res_q.gyro_neg_mask;

endmodule

[src/iaoc_checker.sv]
// port-level checks on the calibrator results, bound to the top level
// uses iaoc_pkg and the assertion macro header
`include "imu_axis_orientation_calibrator_unit_macros.svh"

module iaoc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    phase_o,
  input logic [iaoc_pkg::AxisW-1:0]    z_source_o,
  input logic [iaoc_pkg::AxisW-1:0]    y_source_o,
  input logic [iaoc_pkg::AxisW-1:0]    x_source_o,
  input logic [iaoc_pkg::NumAxes-1:0]  acc_neg_mask_o,
  input logic [iaoc_pkg::NumAxes-1:0]  gyro_neg_mask_o
);
  import iaoc_pkg::*;

  `IAOC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(phase_o) && $stable(z_source_o) && $stable(y_source_o) && $stable(x_source_o) && $stable(acc_neg_mask_o) && $stable(gyro_neg_mask_o))
  `IAOC_ASSERT_IMP(a_src_range, clk_i, rst_ni, out_valid_o, z_source_o != AxisW'(NumAxes) && y_source_o != AxisW'(NumAxes) && x_source_o != AxisW'(NumAxes))
  `IAOC_ASSERT_IMP(a_yz_apart, clk_i, rst_ni, out_valid_o && (phase_o == PhRoll || phase_o == PhDone), y_source_o != z_source_o)
  `IAOC_ASSERT_IMP(a_done_perm, clk_i, rst_ni, out_valid_o && phase_o == PhDone, x_source_o != y_source_o && x_source_o != z_source_o)

endmodule

bind imu_axis_orientation_calibrator_unit iaoc_checker u_iaoc_checker (.*);
